// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising edge outside reset
`define SMIX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define SMIX_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: src/smix_pkg.sv
package smix_pkg;

  localparam int RING_ADDR_BITS = 16;
  localparam int SUM_WIDTH      = 32;

  localparam int SAMPLE_W   = 16;
  localparam int VOL_W      = 9;
  localparam int LOG2_W     = 5;
  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  // largest channel contribution: 16-bit sample times 511, shifted by 8
  localparam int CONTRIB_W  = 18;
  localparam int PROD_W     = SUM_WIDTH + VOL_W + 1;
  localparam int FIN_W      = PROD_W - 8;
  localparam int ADDR_EXT_W = (RING_ADDR_BITS > ADDR_W) ? RING_ADDR_BITS : ADDR_W;

  // queue depth must be a power of two, pointers wrap freely
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_8BIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MONO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE_LOG2 = 2'd3;

  localparam logic [VOL_W-1:0]  MASTER_VOLUME_RESET  = 9'd256;
  localparam logic [LOG2_W-1:0] RING_SIZE_LOG2_RESET = 5'd14;

  localparam logic [15:0] CLIP_MAX      = 16'h7fff;
  localparam logic [15:0] CLIP_MIN      = 16'h8000;
  localparam logic [7:0]  OFFSET_8BIT   = 8'd128;
  localparam logic [4:0]  BYTE_VOL_SAT  = 5'h1f;  // 255 >> 3

  typedef struct packed {
    logic signed [CONTRIB_W-1:0] left;
    logic signed [CONTRIB_W-1:0] right;
    logic                        last;
  } contrib_t;

  typedef struct packed {
    logic [VOL_W-1:0]  master_volume;
    logic              output_8bit;
    logic              output_mono;
    logic [LOG2_W-1:0] ring_size_log2;
  } cfg_t;

  // one side of a channel contribution, both paths share one multiplier
  function automatic logic signed [CONTRIB_W-1:0] scale(
    input logic signed [SAMPLE_W-1:0] s,
    input logic                       is8,
    input logic [VOL_W-1:0]           vol
  );
    logic signed [SAMPLE_W-1:0] a;
    logic signed [VOL_W:0]      g;
    logic signed [25:0]         p;
    a = is8 ? {{8{s[7]}}, s[7:0]} : s;
    g = is8 ? {2'b00, (vol[8] ? BYTE_VOL_SAT : vol[7:3]), 3'b000} : {1'b0, vol};
    p = a * g;
    return is8 ? p[CONTRIB_W-1:0] : p[25:8];
  endfunction

  function automatic logic [SUM_WIDTH-1:0] sext_contrib(
    input logic signed [CONTRIB_W-1:0] c
  );
    return {{(SUM_WIDTH - CONTRIB_W){c[CONTRIB_W-1]}}, c};
  endfunction

  // shift by 8, clip to int16, then optional 8-bit unsigned form
  function automatic logic [15:0] finish(
    input logic signed [PROD_W-1:0] prod,
    input logic                     out8
  );
    logic [FIN_W-1:0] v;
    logic [15:0]      c;
    v = prod[PROD_W-1:8];
    if ((&v[FIN_W-1:15]) || !(|v[FIN_W-1:15])) c = v[15:0];
    else c = v[FIN_W-1] ? CLIP_MIN : CLIP_MAX;
    return out8 ? {8'h00, c[15:8] + OFFSET_8BIT} : c;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(
    input logic [RING_ADDR_BITS-1:0] pos,
    input logic [LOG2_W-1:0]         k
  );
    logic [RING_ADDR_BITS-1:0] mask;
    logic [ADDR_EXT_W-1:0]     ext;
    for (int i = 0; i < RING_ADDR_BITS; i++) mask[i] = (k > LOG2_W'(i));
    ext = ADDR_EXT_W'(pos & mask);
    return ext[ADDR_W-1:0];
  endfunction

endpackage

// File: src/stereo_audio_mixer_with_master_clip_unit.sv
// a closing contribution passes the hold register, queue, sums and products to the output
// register; throughput: one contribution per cycle inside a frame while the queue has room;
// the frame close adds master multiply, then clip and format, and can stall on out_ready.
// reset (rst, synchronous, active high) clears sums, ring position, queue and valid flags,
// and loads master volume 256, 16-bit stereo output and ring size 2^14
module stereo_audio_mixer_with_master_clip_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes
  input  logic                                   cfg_write,
  input  logic [smix_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smix_pkg::CFG_DATA_W-1:0]        cfg_data,
  // channel contribution input
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [smix_pkg::SAMPLE_W-1:0]   sample_value,
  input  logic                                   sample_is_8bit,
  input  logic [smix_pkg::VOL_W-1:0]             left_volume,
  input  logic [smix_pkg::VOL_W-1:0]             right_volume,
  input  logic                                   last_of_frame,
  // mixed frame output
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [15:0]                     out_left,
  output logic signed [15:0]                     out_right,
  output logic [smix_pkg::ADDR_W-1:0]            out_address
);

  // configuration register file
  smix_pkg::cfg_t     cfg;

  // front to queue to back
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  smix_pkg::contrib_t q_wr_data;
  smix_pkg::contrib_t q_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_volume  <= smix_pkg::MASTER_VOLUME_RESET;
      cfg.output_8bit    <= 1'b0;
      cfg.output_mono    <= 1'b0;
      cfg.ring_size_log2 <= smix_pkg::RING_SIZE_LOG2_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        smix_pkg::REG_MASTER_VOLUME:  cfg.master_volume  <= cfg_data;
        smix_pkg::REG_OUTPUT_8BIT:    cfg.output_8bit    <= cfg_data[0];
        smix_pkg::REG_OUTPUT_MONO:    cfg.output_mono    <= cfg_data[0];
        smix_pkg::REG_RING_SIZE_LOG2: cfg.ring_size_log2 <= cfg_data[smix_pkg::LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // front: registers the transaction and scales it by the left and right volumes
  smix_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .sample_is_8bit (sample_is_8bit),
    .left_volume    (left_volume),
    .right_volume   (right_volume),
    .last_of_frame  (last_of_frame),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  // short queue so the front keeps taking contributions while a frame closes
  smix_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // back: accumulates, applies master gain, clips and formats the frame
  smix_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_left    (out_left),
    .out_right   (out_right),
    .out_address (out_address)
  );

endmodule

// File: src/smix_front.sv
module smix_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [smix_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                 sample_is_8bit,
  input  logic [smix_pkg::VOL_W-1:0]           left_volume,
  input  logic [smix_pkg::VOL_W-1:0]           right_volume,
  input  logic                                 last_of_frame,
  input  logic                                 q_full,
  output logic                                 q_push,
  output smix_pkg::contrib_t                   q_data
);

  logic                                 hold_valid;
  logic signed [smix_pkg::SAMPLE_W-1:0] h_sample;
  logic                                 h_is8;
  logic [smix_pkg::VOL_W-1:0]           h_lvol;
  logic [smix_pkg::VOL_W-1:0]           h_rvol;
  logic                                 h_last;

  assign q_push   = hold_valid && !q_full;
  assign in_ready = !hold_valid || !q_full;

  always_comb begin
    q_data.left  = smix_pkg::scale(h_sample, h_is8, h_lvol);
    q_data.right = smix_pkg::scale(h_sample, h_is8, h_rvol);
    q_data.last  = h_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      h_sample <= sample_value;
      h_is8    <= sample_is_8bit;
      h_lvol   <= left_volume;
      h_rvol   <= right_volume;
      h_last   <= last_of_frame;
    end
  end

endmodule

// File: src/smix_fifo.sv
`include "assert_macros.svh"

module smix_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  smix_pkg::contrib_t wr_data,
  output logic               full,
  input  logic               pop,
  output smix_pkg::contrib_t rd_data,
  output logic               empty
);

  smix_pkg::contrib_t                 mem [smix_pkg::FIFO_DEPTH];
  logic [smix_pkg::FIFO_PTR_W-1:0]    wr_ptr;
  logic [smix_pkg::FIFO_PTR_W-1:0]    rd_ptr;
  logic [smix_pkg::FIFO_CNT_W-1:0]    count;

  assign full    = (count == smix_pkg::FIFO_CNT_W'(smix_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= wr_data;
  end

  `SMIX_ASSERT(a_no_overflow, clk, rst, !(push && full), "push into a full queue")
  `SMIX_ASSERT(a_no_underflow, clk, rst, !(pop && empty), "pop from an empty queue")
  `SMIX_ASSERT_NEXT(a_count_idle, clk, rst, !push && !pop, $stable(count), "count moved while idle")

endmodule

// File: src/smix_back.sv
`include "assert_macros.svh"

module smix_back (
  input  logic                                clk,
  input  logic                                rst,
  input  smix_pkg::cfg_t                      cfg,
  input  logic                                q_empty,
  input  smix_pkg::contrib_t                  q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  out_left,
  output logic signed [15:0]                  out_right,
  output logic [smix_pkg::ADDR_W-1:0]         out_address
);

  typedef enum logic [2:0] {
    ST_ACC = 3'b001,
    ST_MUL = 3'b010,
    ST_FIN = 3'b100
  } back_state_t;

  back_state_t                            state;
  back_state_t                            state_next;
  logic [smix_pkg::SUM_WIDTH-1:0]         left_sum;
  logic [smix_pkg::SUM_WIDTH-1:0]         right_sum;
  logic signed [smix_pkg::PROD_W-1:0]     prod_l;
  logic signed [smix_pkg::PROD_W-1:0]     prod_r;
  logic [smix_pkg::RING_ADDR_BITS-1:0]    ring_pos;
  logic                                   load;

  assign q_pop = (state == ST_ACC) && !q_empty;
  assign load  = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC: if (q_pop && q_data.last) state_next = ST_MUL;
      ST_MUL: state_next = ST_FIN;
      ST_FIN: if (load) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      left_sum  <= '0;
      right_sum <= '0;
      ring_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        left_sum  <= left_sum + smix_pkg::sext_contrib(q_data.left);
        right_sum <= right_sum + smix_pkg::sext_contrib(q_data.right);
      end else if (state == ST_MUL) begin
        left_sum  <= '0;
        right_sum <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
        ring_pos  <= ring_pos + (cfg.output_mono ? smix_pkg::RING_ADDR_BITS'(1)
                                                 : smix_pkg::RING_ADDR_BITS'(2));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (state == ST_MUL) begin
      prod_l <= $signed(left_sum) * $signed({1'b0, cfg.master_volume});
      prod_r <= $signed(right_sum) * $signed({1'b0, cfg.master_volume});
    end
    if (load) begin
      out_left    <= smix_pkg::finish(prod_l, cfg.output_8bit);
      out_right   <= cfg.output_mono ? 16'sd0 : smix_pkg::finish(prod_r, cfg.output_8bit);
      out_address <= smix_pkg::ring_addr(ring_pos, cfg.ring_size_log2);
    end
  end

  `SMIX_ASSERT(a_sums_cleared, clk, rst, state != ST_FIN || (left_sum == '0 && right_sum == '0), "sums not cleared before output")
  `SMIX_ASSERT_NEXT(a_last_closes, clk, rst, q_pop && q_data.last, state == ST_MUL, "last contribution did not close the frame")

endmodule

// File: tb/testbench.sv
module testbench;
  import smix_pkg::*;

  // run ends here no matter what, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  // closing contribution passes the hold register, queue, sums and products before the output register
  localparam int DRAIN_CYCLES = 8;

  // one channel contribution as seen on the input channel
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is8;
    logic [VOL_W-1:0]           left_vol;
    logic [VOL_W-1:0]           right_vol;
    logic                       last;
  } contribution_t;

  // one mixed output frame
  typedef struct {
    logic [15:0]       left;
    logic [15:0]       right;
    logic [ADDR_W-1:0] address;
  } frame_t;

  // receiver stall patterns
  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_PATTERN, READY_RARELY} stall_mode_e;

  // mixer predictor plus store of frames still owed by the block
  class frame_mix_scoreboard;
    logic [VOL_W-1:0]          master_volume;
    logic                      out8;
    logic                      mono;
    logic [LOG2_W-1:0]         ring_log2;
    logic [SUM_WIDTH-1:0]      left_sum;
    logic [SUM_WIDTH-1:0]      right_sum;
    logic [RING_ADDR_BITS-1:0] ring_pos;
    frame_t                    owed_frames[$];
    int                        mismatches;
    int                        frames_checked;

    function new();
      master_volume  = MASTER_VOLUME_RESET;
      out8           = 1'b0;
      mono           = 1'b0;
      ring_log2      = RING_SIZE_LOG2_RESET;
      left_sum       = '0;
      right_sum      = '0;
      ring_pos       = '0;
      mismatches     = 0;
      frames_checked = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MASTER_VOLUME:  master_volume = data[VOL_W-1:0];
        REG_OUTPUT_8BIT:    out8 = data[0];
        REG_OUTPUT_MONO:    mono = data[0];
        REG_RING_SIZE_LOG2: ring_log2 = data[LOG2_W-1:0];
        default: ;
      endcase
    endfunction

    // one side of a contribution: byte path uses a coarse gain, word path a multiply
    function longint side_gain(logic signed [SAMPLE_W-1:0] s, logic is8,
                               logic [VOL_W-1:0] vol);
      longint b;
      longint g;
      if (is8) begin
        b = $signed(s[7:0]);
        g = (vol > 9'd255) ? 64'd255 : 64'(vol);
        return b * ((g >> 3) * 8);
      end
      b = s;
      g = 64'(vol);
      return (b * g) >>> 8;
    endfunction

    // master gain on the wrapped sum, clip to int16, optional unsigned byte form
    function logic [15:0] master_clip(logic [SUM_WIDTH-1:0] sum);
      longint v;
      v = $signed(sum);
      v = (v * longint'(master_volume)) >>> 8;
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      if (out8) return 16'(((v >>> 8) + 128) & 255);
      return v[15:0];
    endfunction

    function void add_contribution(contribution_t c);
      frame_t      f;
      int unsigned k;
      int unsigned rmask;
      left_sum  = left_sum + SUM_WIDTH'(side_gain(c.sample, c.is8, c.left_vol));
      right_sum = right_sum + SUM_WIDTH'(side_gain(c.sample, c.is8, c.right_vol));
      if (!c.last) return;
      k = (ring_log2 > RING_ADDR_BITS) ? RING_ADDR_BITS : ring_log2;
      rmask = (1 << k) - 1;
      f.left    = master_clip(left_sum);
      f.right   = mono ? 16'd0 : master_clip(right_sum);
      f.address = ADDR_W'(ring_pos & RING_ADDR_BITS'(rmask));
      owed_frames.push_back(f);
      left_sum  = '0;
      right_sum = '0;
      ring_pos  = ring_pos + (mono ? 1 : 2);
    endfunction

    function void flag(string msg);
      if (mismatches < MAX_REPORTS) $display("%s", msg);
      mismatches++;
    endfunction

    function void check_frame(logic [15:0] l, logic [15:0] r, logic [ADDR_W-1:0] a);
      frame_t f;
      frames_checked++;
      if (owed_frames.size() == 0) begin
        flag($sformatf("unexpected frame: left %h right %h address %h", l, r, a));
        return;
      end
      f = owed_frames.pop_front();
      if (f.left !== l || f.right !== r || f.address !== a)
        flag($sformatf("frame mismatch: expected left %h right %h address %h, got %h %h %h",
                       f.left, f.right, f.address, l, r, a));
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_write;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [SAMPLE_W-1:0]   sample_value;
  logic                         sample_is_8bit;
  logic [VOL_W-1:0]             left_volume;
  logic [VOL_W-1:0]             right_volume;
  logic                         last_of_frame;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [15:0]           out_left;
  logic signed [15:0]           out_right;
  logic [ADDR_W-1:0]            out_address;

  frame_mix_scoreboard model;
  int                  burst_left;
  int                  cycles;

  stereo_audio_mixer_with_master_clip_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .sample_is_8bit (sample_is_8bit),
    .left_volume    (left_volume),
    .right_volume   (right_volume),
    .last_of_frame  (last_of_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left       (out_left),
    .out_right      (out_right),
    .out_address    (out_address)
  );

  // 8 unit period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // sample mix: extremes, tiny values around zero, byte extremes with junk above
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 8))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 16)) - 16'd8;
      3: return {8'($urandom), 8'h7f};
      4: return {8'($urandom), 8'h80};
      default: return 16'($urandom);
    endcase
  endfunction

  // volumes lean on the byte-path clamp edges and the ends of the range
  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd511;
      2: return 9'd255;
      3: return 9'd256;
      4: return 9'($urandom_range(0, 8));
      default: return 9'($urandom);
    endcase
  endfunction

  // sender pacing: bursts of random length, gaps between, sometimes no gap at all
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // present one contribution at a falling edge and hold it until taken
  task automatic offer(contribution_t c);
    bit taken;
    sample_value   = c.sample;
    sample_is_8bit = c.is8;
    left_volume    = c.left_vol;
    right_volume   = c.right_vol;
    last_of_frame  = c.last;
    in_valid       = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
      if (taken) model.add_contribution(c);
      @(negedge clk);
    end
    pace_sender();
  endtask

  task automatic contribute(logic [15:0] s, logic is8, logic [VOL_W-1:0] lv,
                            logic [VOL_W-1:0] rv, logic last);
    contribution_t c;
    c.sample    = s;
    c.is8       = is8;
    c.left_vol  = lv;
    c.right_vol = rv;
    c.last      = last;
    offer(c);
  endtask

  // mostly short frames, a few long ones that push the sums into the clip
  task automatic mix_random_frames(int count);
    contribution_t c;
    int            len;
    while (count > 0) begin
      case ($urandom_range(0, 19))
        0:             len = $urandom_range(11, 24);
        1, 2, 3, 4, 5: len = $urandom_range(5, 10);
        default:       len = $urandom_range(1, 4);
      endcase
      for (int i = 0; i < len; i++) begin
        c.sample    = pick_sample();
        c.is8       = 1'($urandom_range(0, 1));
        c.left_vol  = pick_volume();
        c.right_vol = pick_volume();
        c.last      = (i == len - 1);
        offer(c);
      end
      count -= len;
    end
  endtask

  // let every owed frame come out, then let the pipeline drain
  task automatic settle();
    in_valid = 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // junk in the unused data bits of narrow registers must be ignored
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    case (idx)
      REG_OUTPUT_8BIT, REG_OUTPUT_MONO: data[CFG_DATA_W-1:1] = 8'($urandom);
      REG_RING_SIZE_LOG2:               data[CFG_DATA_W-1:LOG2_W] = 4'($urandom);
      default: ;
    endcase
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
    model.write_register(idx, data);
  endtask

  task automatic configure(int master, int out8, int mono, int ring_log2);
    settle();
    write_register(REG_MASTER_VOLUME, master);
    write_register(REG_OUTPUT_8BIT, out8);
    write_register(REG_OUTPUT_MONO, mono);
    write_register(REG_RING_SIZE_LOG2, ring_log2);
  endtask

  // hand-picked frames under the reset configuration
  task automatic directed_frames();
    contribute(16'h7fff, 1'b0, 9'd511, 9'd511, 1'b1);   // clips high
    contribute(16'h8000, 1'b0, 9'd511, 9'd511, 1'b1);   // clips low
    contribute(16'hffff, 1'b0, 9'd1, 9'd0, 1'b1);       // arithmetic shift keeps -1
    contribute(16'h007f, 1'b1, 9'd511, 9'd256, 1'b1);   // byte gain clamp
    contribute(16'hff80, 1'b1, 9'd255, 9'd7, 1'b1);     // byte -128, gain rounds to 0
    contribute(16'h12ff, 1'b1, 9'd8, 9'd0, 1'b0);       // upper byte ignored
    contribute(16'h1234, 1'b0, 9'd256, 9'd128, 1'b0);
    contribute(16'h8000, 1'b0, 9'd511, 9'd0, 1'b0);
    contribute(16'h7fff, 1'b0, 9'd0, 9'd511, 1'b1);
    contribute(16'h0000, 1'b0, 9'd0, 9'd0, 1'b1);
    repeat (4) contribute(16'h4000, 1'b0, 9'd256, 9'd256, 1'b0);
    contribute(16'h0001, 1'b0, 9'd256, 9'd256, 1'b1);  // sum past int16
    contribute(16'h5555, 1'b1, 9'h155, 9'h0aa, 1'b1);
    contribute(16'haaaa, 1'b0, 9'h0aa, 9'h155, 1'b1);
  endtask

  // receiver: stall pattern changes now and then, long hold-offs fill the block
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    int          next_hold;
    int          tick;
    out_ready = 1'b0;
    mode      = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    next_hold = 150;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) model.check_frame(out_left, out_right, out_address);
      @(negedge clk);
      tick++;
      if (model.frames_checked >= next_hold) begin
        hold_left = 400;
        next_hold += 230;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS:  out_ready = 1'b1;
          READY_MOSTLY:  out_ready = ($urandom_range(0, 3) != 0);
          READY_PATTERN: out_ready = ((tick % 7) < 3);
          default:       out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // main sequence: directed frames, then random phases over a spread of settings
  initial begin
    model          = new();
    burst_left     = 0;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_MASTER_VOLUME;
    cfg_data       = '0;
    in_valid       = 1'b0;
    sample_value   = '0;
    sample_is_8bit = 1'b0;
    left_volume    = '0;
    right_volume   = '0;
    last_of_frame  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_frames();
    mix_random_frames(225);
    // full gain, widest ring
    configure(511, 0, 0, 16);
    mix_random_frames(225);
    // silent master in byte output, two-sample ring
    configure(0, 1, 0, 1);
    mix_random_frames(200);
    // mono byte output, zero-size ring pins the address
    configure(256, 1, 1, 0);
    mix_random_frames(225);
    // ring size past the address width saturates
    configure(300, 0, 1, 17);
    mix_random_frames(225);
    configure(128, 0, 0, 31);
    mix_random_frames(225);
    configure($urandom_range(0, 511), 1, 0, $urandom_range(0, 31));
    mix_random_frames(225);
    configure(1, 0, 1, 4);
    mix_random_frames(225);
    settle();

    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/smix_pkg.sv
src/smix_front.sv
src/smix_fifo.sv
src/smix_back.sv
src/stereo_audio_mixer_with_master_clip_unit.sv
tb/testbench.sv
